// File: src/gtm_pkg.sv
// Shared types, codes and defaults for the grid tile map table.
`default_nettype none
package gtm_pkg;

   localparam int TILE_SLOTS_DEF   = 256;
   localparam int COORD_BITS_DEF   = 8;
   localparam int PAYLOAD_BITS_DEF = 16;

   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_FIND  = 2'd1;
   localparam logic [1:0] ACT_NEIGH = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_NONE  = 2'd2;

   localparam logic [1:0] DIR_EAST  = 2'd0;
   localparam logic [1:0] DIR_NORTH = 2'd1;
   localparam logic [1:0] DIR_WEST  = 2'd2;
   localparam logic [1:0] DIR_SOUTH = 2'd3;

   typedef enum logic [1:0] {
      KIND_ADD,
      KIND_FIND,
      KIND_NEIGH,
      KIND_BAD
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [1:0] dir;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_SCAN_RD,
      ST_SCAN,
      ST_LINK_WR,
      ST_FIND_RD,
      ST_FIND,
      ST_NB_RD,
      ST_NB_CHK,
      ST_NB_OUT,
      ST_RESP
   } state_type;

endpackage
`default_nettype wire

// File: src/gtm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gtm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// File: src/gtm_front.sv
// Front end: takes requests, classifies the action and queues commands.
`default_nettype none
module gtm_front import gtm_pkg::*; #(
   parameter int IDX_BITS     = 8,
   parameter int COORD_BITS   = COORD_BITS_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire logic [1:0]              in_action,
   input  wire logic [IDX_BITS-1:0]     in_index,
   input  wire logic [1:0]              in_dir,
   input  wire logic [PAYLOAD_BITS-1:0] in_payload,
   input  wire logic [COORD_BITS-1:0]   in_x,
   input  wire logic [COORD_BITS-1:0]   in_y,
   output logic                         cmd_valid,
   input  wire logic                    cmd_ready,
   output cmd_type                      cmd,
   output logic [IDX_BITS-1:0]          cmd_index,
   output logic [PAYLOAD_BITS-1:0]      cmd_payload,
   output logic [COORD_BITS-1:0]        cmd_x,
   output logic [COORD_BITS-1:0]        cmd_y
);
   cmd_type                 q_cmd_ff     [2];
   logic [IDX_BITS-1:0]     q_index_ff   [2];
   logic [PAYLOAD_BITS-1:0] q_payload_ff [2];
   logic [COORD_BITS-1:0]   q_x_ff       [2];
   logic [COORD_BITS-1:0]   q_y_ff       [2];
   logic                    wr_ptr_ff, wr_ptr_in;
   logic                    rd_ptr_ff, rd_ptr_in;
   logic [1:0]              count_ff, count_in;
   cmd_type                 new_cmd;
   logic                    push, pop;

   always_comb begin
      new_cmd.dir = in_dir;
      unique case (in_action)
         ACT_ADD:   new_cmd.kind = KIND_ADD;
         ACT_FIND:  new_cmd.kind = KIND_FIND;
         ACT_NEIGH: new_cmd.kind = KIND_NEIGH;
         default:   new_cmd.kind = KIND_BAD;
      endcase
   end

   assign in_ready    = (count_ff != 2'd2);
   assign cmd_valid   = (count_ff != 2'd0);
   assign push        = in_valid && in_ready;
   assign pop         = cmd_valid && cmd_ready;
   assign cmd         = q_cmd_ff[rd_ptr_ff];
   assign cmd_index   = q_index_ff[rd_ptr_ff];
   assign cmd_payload = q_payload_ff[rd_ptr_ff];
   assign cmd_x       = q_x_ff[rd_ptr_ff];
   assign cmd_y       = q_y_ff[rd_ptr_ff];
   assign wr_ptr_in   = wr_ptr_ff ^ push;
   assign rd_ptr_in   = rd_ptr_ff ^ pop;
   assign count_in    = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_cmd_ff[wr_ptr_ff]     <= new_cmd;
         q_index_ff[wr_ptr_ff]   <= in_index;
         q_payload_ff[wr_ptr_ff] <= in_payload;
         q_x_ff[wr_ptr_ff]       <= in_x;
         q_y_ff[wr_ptr_ff]       <= in_y;
      end
   end
endmodule
`default_nettype wire

// File: src/gtm_back.sv
// Back end: sequencer over the tile and link memories that executes commands.
`default_nettype none
module gtm_back import gtm_pkg::*; #(
   parameter int TILE_SLOTS   = TILE_SLOTS_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             cmd_valid,
   output logic                                  cmd_ready,
   input  wire cmd_type                          cmd,
   input  wire logic [$clog2(TILE_SLOTS)-1:0]    cmd_index,
   input  wire logic [PAYLOAD_BITS-1:0]          cmd_payload,
   input  wire logic [COORD_BITS-1:0]            cmd_x,
   input  wire logic [COORD_BITS-1:0]            cmd_y,
   output logic                                  out_valid,
   input  wire logic                             out_ready,
   output logic [1:0]                            out_status,
   output logic [$clog2(TILE_SLOTS)-1:0]         out_index,
   output logic [COORD_BITS-1:0]                 out_x,
   output logic [COORD_BITS-1:0]                 out_y,
   output logic [PAYLOAD_BITS-1:0]               out_payload
);
   localparam int IB = $clog2(TILE_SLOTS);
   localparam int LB = IB + 1;
   localparam int RW = 2 * COORD_BITS + PAYLOAD_BITS;
   localparam int LW = 4 * LB;
   localparam logic [IB-1:0] LAST_SLOT = IB'(TILE_SLOTS - 1);
   localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

   state_type state_ff, state_in;
   logic [IB-1:0]           last_ff, last_in;
   logic [IB-1:0]           idx_ff, idx_in;
   logic [IB-1:0]           base_ff, base_in;
   logic [1:0]              dir_ff, dir_in;
   logic [1:0]              kind_dir;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic [COORD_BITS-1:0]   fx_ff, fx_in, fy_ff, fy_in;
   logic [COORD_BITS-1:0]   nx_ff, nx_in, ny_ff, ny_in;
   logic [3:0][LB-1:0]      nl_ff, nl_in;
   logic [1:0]              rs_ff, rs_in;
   logic [IB-1:0]           ri_ff, ri_in;
   logic [COORD_BITS-1:0]   rx_ff, rx_in, ry_ff, ry_in;
   logic [PAYLOAD_BITS-1:0] rp_ff, rp_in;
   logic                    ov_ff, ov_in;
   logic [1:0]              os_ff, os_in;
   logic [IB-1:0]           oi_ff, oi_in;
   logic [COORD_BITS-1:0]   ox_ff, ox_in, oy_ff, oy_in;
   logic [PAYLOAD_BITS-1:0] op_ff, op_in;

   logic [IB-1:0]           rd_addr, rec_waddr, lnk_waddr;
   logic                    rec_we, lnk_we;
   logic [RW-1:0]           rec_wdata, rec_rd;
   logic [LW-1:0]           lnk_wdata, lnk_rd;
   logic [3:0][LB-1:0]      row, row_mod;
   logic [COORD_BITS-1:0]   rec_x, rec_y, cx, cy;
   logic [PAYLOAD_BITS-1:0] rec_p;
   logic [3:0]              hit;
   logic [1:0]              hd;
   logic                    any_hit, out_free;

   assign rec_x    = rec_rd[COORD_BITS-1:0];
   assign rec_y    = rec_rd[2*COORD_BITS-1:COORD_BITS];
   assign rec_p    = rec_rd[RW-1:2*COORD_BITS];
   assign row      = lnk_rd;
   assign out_free = !ov_ff || out_ready;
   assign kind_dir = cmd.dir;

   // Candidate positions around the new tile, east/north/west/south.
   always_comb begin
      hit = 4'b0;
      hit[0] = !nl_ff[0][IB] && rec_x == nx_ff + ONE && rec_y == ny_ff;
      hit[1] = !nl_ff[1][IB] && rec_x == nx_ff && rec_y == ny_ff + ONE;
      hit[2] = !nl_ff[2][IB] && rec_x == nx_ff - ONE && rec_y == ny_ff;
      hit[3] = !nl_ff[3][IB] && rec_x == nx_ff && rec_y == ny_ff - ONE;
      any_hit = |hit;
      priority if (hit[0]) hd = DIR_EAST;
      else if (hit[1])     hd = DIR_NORTH;
      else if (hit[2])     hd = DIR_WEST;
      else                 hd = DIR_SOUTH;
   end

   always_comb begin
      cx = rec_x;
      cy = rec_y;
      unique case (dir_ff)
         DIR_EAST:  cx = rec_x + ONE;
         DIR_NORTH: cy = rec_y + ONE;
         DIR_WEST:  cx = rec_x - ONE;
         DIR_SOUTH: cy = rec_y - ONE;
         default:   cx = rec_x;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      last_in = last_ff; idx_in = idx_ff; base_in = base_ff; dir_in = dir_ff;
      pay_in = pay_ff; fx_in = fx_ff; fy_in = fy_ff; nx_in = nx_ff; ny_in = ny_ff;
      nl_in = nl_ff;
      rs_in = rs_ff; ri_in = ri_ff; rx_in = rx_ff; ry_in = ry_ff; rp_in = rp_ff;
      ov_in = ov_ff && !out_ready;
      os_in = os_ff; oi_in = oi_ff; ox_in = ox_ff; oy_in = oy_ff; op_in = op_ff;
      cmd_ready = 1'b0;
      rd_addr = '0;
      rec_we = 1'b0; rec_waddr = '0; rec_wdata = '0;
      lnk_we = 1'b0; lnk_waddr = '0; lnk_wdata = '0;
      row_mod = row;
      unique case (state_ff)
         ST_INIT: begin
            rec_we = 1'b1;
            lnk_we = 1'b1;
            last_in = '0;
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               base_in = cmd_index; dir_in = kind_dir; pay_in = cmd_payload;
               fx_in = cmd_x; fy_in = cmd_y;
               rs_in = STAT_NONE; ri_in = '0; rx_in = '0; ry_in = '0; rp_in = '0;
               unique case (cmd.kind)
                  KIND_ADD: begin
                     if (last_ff == LAST_SLOT) begin
                        rs_in = STAT_FULL;
                        state_in = ST_RESP;
                     end else if (cmd_index > last_ff) begin
                        state_in = ST_RESP;
                     end else begin
                        state_in = ST_ADD_RD;
                     end
                  end
                  KIND_FIND: state_in = ST_FIND_RD;
                  KIND_NEIGH: begin
                     state_in = (cmd_index > last_ff) ? ST_RESP : ST_NB_RD;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_ADD_RD: begin
            rd_addr = base_ff;
            state_in = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            // Place the new tile and link it back to its base both ways.
            last_in = last_ff + IB'(1);
            nx_in = cx;
            ny_in = cy;
            rec_we = 1'b1;
            rec_waddr = last_in;
            rec_wdata = {pay_ff, cy, cx};
            row_mod[dir_ff] = {1'b1, last_in};
            lnk_we = 1'b1;
            lnk_waddr = base_ff;
            lnk_wdata = row_mod;
            nl_in = '0;
            nl_in[dir_ff + 2'd2] = {1'b1, base_ff};
            state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            rd_addr = '0;
            idx_in = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            rd_addr = idx_ff + IB'(1);
            idx_in = idx_ff + IB'(1);
            if (any_hit) begin
               nl_in[hd] = {1'b1, idx_ff};
               row_mod[hd + 2'd2] = {1'b1, last_ff};
               lnk_we = 1'b1;
               lnk_waddr = idx_ff;
               lnk_wdata = row_mod;
            end
            if (idx_ff == last_ff) begin
               state_in = ST_LINK_WR;
            end
         end
         ST_LINK_WR: begin
            lnk_we = 1'b1;
            lnk_waddr = last_ff;
            lnk_wdata = nl_ff;
            rs_in = STAT_OK; ri_in = last_ff; rx_in = nx_ff; ry_in = ny_ff;
            rp_in = pay_ff;
            state_in = ST_RESP;
         end
         ST_FIND_RD: begin
            rd_addr = '0;
            idx_in = '0;
            state_in = ST_FIND;
         end
         ST_FIND: begin
            rd_addr = idx_ff + IB'(1);
            idx_in = idx_ff + IB'(1);
            if (rec_x == fx_ff && rec_y == fy_ff) begin
               rs_in = STAT_OK; ri_in = idx_ff; rx_in = rec_x; ry_in = rec_y;
               rp_in = rec_p;
               state_in = ST_RESP;
            end else if (idx_ff == last_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_NB_RD: begin
            rd_addr = base_ff;
            state_in = ST_NB_CHK;
         end
         ST_NB_CHK: begin
            rd_addr = row[dir_ff][IB-1:0];
            idx_in = row[dir_ff][IB-1:0];
            state_in = row[dir_ff][IB] ? ST_NB_OUT : ST_RESP;
         end
         ST_NB_OUT: begin
            rs_in = STAT_OK; ri_in = idx_ff; rx_in = rec_x; ry_in = rec_y;
            rp_in = rec_p;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               ov_in = 1'b1;
               os_in = rs_ff; oi_in = ri_ff; ox_in = rx_ff; oy_in = ry_ff;
               op_in = rp_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         ov_ff    <= 1'b0;
         last_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in; base_ff <= base_in; dir_ff <= dir_in; pay_ff <= pay_in;
      fx_ff <= fx_in; fy_ff <= fy_in; nx_ff <= nx_in; ny_ff <= ny_in;
      nl_ff <= nl_in;
      rs_ff <= rs_in; ri_ff <= ri_in; rx_ff <= rx_in; ry_ff <= ry_in; rp_ff <= rp_in;
      os_ff <= os_in; oi_ff <= oi_in; ox_ff <= ox_in; oy_ff <= oy_in; op_ff <= op_in;
   end

   assign out_valid   = ov_ff;
   assign out_status  = os_ff;
   assign out_index   = oi_ff;
   assign out_x       = ox_ff;
   assign out_y       = oy_ff;
   assign out_payload = op_ff;

   gtm_ram #(.WIDTH(RW), .DEPTH(TILE_SLOTS)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_waddr),
      .wr_data (rec_wdata),
      .rd_addr (rd_addr),
      .rd_data (rec_rd)
   );

   gtm_ram #(.WIDTH(LW), .DEPTH(TILE_SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (lnk_we),
      .wr_addr (lnk_waddr),
      .wr_data (lnk_wdata),
      .rd_addr (rd_addr),
      .rd_data (lnk_rd)
   );
endmodule
`default_nettype wire

// File: src/grid_tile_map_table.sv
// Top level of the grid tile map table: request unpacking, front queue and back sequencer.
// Add and find walk the tile memory one entry per cycle; neighbor follows the stored links,
// and rejected requests go straight to the response.
// The back end takes one request at a time; the front queue buffers up to two waiting requests.
// Reset: synchronous, active high; clears the queue and output valid, then writes the start
// tile (entry 0 at the origin, no links) in its init state before taking requests.
`default_nettype none
module grid_tile_map_table import gtm_pkg::*; #(
   parameter int TILE_SLOTS   = TILE_SLOTS_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
   parameter int IB = $clog2(TILE_SLOTS),
   parameter int REQ_W = ((4 + IB + PAYLOAD_BITS + 2 * COORD_BITS + 7) / 8) * 8,
   parameter int RSP_W = ((2 + IB + PAYLOAD_BITS + 2 * COORD_BITS + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // action, tile_index, direction, tile_payload, find_x, find_y, zero pad
   input  wire logic [REQ_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // status, result_index, result_x, result_y, result_payload, zero pad
   output logic [RSP_W-1:0]      rsp_tdata
);
   localparam int P_IDX = 2;
   localparam int P_DIR = P_IDX + IB;
   localparam int P_PAY = P_DIR + 2;
   localparam int P_FX  = P_PAY + PAYLOAD_BITS;
   localparam int P_FY  = P_FX + COORD_BITS;

   cmd_type                 cmd;
   logic                    cmd_valid, cmd_ready;
   logic [IB-1:0]           cmd_index;
   logic [PAYLOAD_BITS-1:0] cmd_payload;
   logic [COORD_BITS-1:0]   cmd_x, cmd_y;
   logic [1:0]              o_status;
   logic [IB-1:0]           o_index;
   logic [COORD_BITS-1:0]   o_x, o_y;
   logic [PAYLOAD_BITS-1:0] o_payload;

   // Front: classify and buffer up to two requests.
   gtm_front #(.IDX_BITS(IB), .COORD_BITS(COORD_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_action   (req_tdata[1:0]),
      .in_index    (req_tdata[P_DIR-1:P_IDX]),
      .in_dir      (req_tdata[P_PAY-1:P_DIR]),
      .in_payload  (req_tdata[P_FX-1:P_PAY]),
      .in_x        (req_tdata[P_FY-1:P_FX]),
      .in_y        (req_tdata[P_FY+COORD_BITS-1:P_FY]),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd),
      .cmd_index   (cmd_index),
      .cmd_payload (cmd_payload),
      .cmd_x       (cmd_x),
      .cmd_y       (cmd_y)
   );

   // Back: walk the table and hold the result in the output register.
   gtm_back #(
      .TILE_SLOTS(TILE_SLOTS), .COORD_BITS(COORD_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd),
      .cmd_index   (cmd_index),
      .cmd_payload (cmd_payload),
      .cmd_x       (cmd_x),
      .cmd_y       (cmd_y),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_status  (o_status),
      .out_index   (o_index),
      .out_x       (o_x),
      .out_y       (o_y),
      .out_payload (o_payload)
   );

   assign rsp_tdata = RSP_W'({o_payload, o_y, o_x, o_index, o_status});
endmodule
`default_nettype wire

// File: bench/tb_grid_tile_map_table.sv
// Testbench for the grid tile map table: directed table plus random requests, scoreboarded.
`timescale 1ns / 1ps
module tb_grid_tile_map_table import gtm_pkg::*;;

   localparam int SLOTS = 256;
   localparam int REQ_W = 48;
   localparam int RSP_W = 48;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // one request as the block sees it
   typedef struct {
      logic [1:0]  action;
      logic [7:0]  tile_index;
      logic [1:0]  direction;
      logic [15:0] tile_payload;
      logic [7:0]  find_x;
      logic [7:0]  find_y;
   } tile_req_type;

   // one response
   typedef struct {
      logic [1:0]  status;
      logic [7:0]  result_index;
      logic [7:0]  result_x;
      logic [7:0]  result_y;
      logic [15:0] result_payload;
   } tile_rsp_type;

   // one directed row: request, whether the response is typed in, and that response
   typedef struct {
      tile_req_type q;
      bit           fixed;
      tile_rsp_type exp;
   } row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   grid_tile_map_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Shadow copy of the tile map, advanced once per accepted request.
   int unsigned map_last;
   logic [7:0]  map_x [SLOTS];
   logic [7:0]  map_y [SLOTS];
   logic [15:0] map_pay [SLOTS];
   logic [7:0]  map_link [SLOTS][4];
   bit          map_link_ok [SLOTS][4];

   tile_rsp_type pending_rsp [$];
   int           fail_count = 0;
   int           send_idle_pct = 27;
   int           recv_idle_pct = 79;
   bit           hold_off = 1'b0;

   function automatic logic [7:0] step_x(logic [7:0] x, logic [1:0] d);
      case (d)
         DIR_EAST: return x + 8'd1;
         DIR_WEST: return x - 8'd1;
         default:  return x;
      endcase
   endfunction

   function automatic logic [7:0] step_y(logic [7:0] y, logic [1:0] d);
      case (d)
         DIR_NORTH: return y + 8'd1;
         DIR_SOUTH: return y - 8'd1;
         default:   return y;
      endcase
   endfunction

   function automatic tile_rsp_type tile_view(int unsigned idx);
      tile_rsp_type r;
      r.status = STAT_OK;
      r.result_index = idx[7:0];
      r.result_x = map_x[idx];
      r.result_y = map_y[idx];
      r.result_payload = map_pay[idx];
      return r;
   endfunction

   function automatic tile_rsp_type rsp(logic [1:0] st, logic [7:0] i, logic [7:0] x,
                                        logic [7:0] y, logic [15:0] p);
      tile_rsp_type r;
      r = '{st, i, x, y, p};
      return r;
   endfunction

   function automatic tile_rsp_type miss(logic [1:0] st);
      return rsp(st, 8'd0, 8'd0, 8'd0, 16'd0);
   endfunction

   // Apply one request to the shadow map and return the response it should draw.
   function automatic tile_rsp_type map_apply(tile_req_type q);
      int unsigned n;
      int unsigned b;
      logic [1:0]  d;
      b = q.tile_index;
      d = q.direction;
      case (q.action)
         ACT_ADD: begin
            if (map_last >= SLOTS - 1) return miss(STAT_FULL);
            if (b > map_last) return miss(STAT_NONE);
            n = map_last + 1;
            map_last = n;
            map_pay[n] = q.tile_payload;
            map_x[n] = step_x(map_x[b], d);
            map_y[n] = step_y(map_y[b], d);
            for (int k = 0; k < 4; k++) begin
               map_link_ok[n][k] = 1'b0;
               map_link[n][k] = '0;
            end
            map_link[b][d] = n[7:0];
            map_link_ok[b][d] = 1'b1;
            map_link[n][d ^ 2'd2] = b[7:0];
            map_link_ok[n][d ^ 2'd2] = 1'b1;
            // scan every stored tile, the new one included
            for (int unsigned i = 0; i <= map_last; i++) begin
               for (int k = 0; k < 4; k++) begin
                  if (!map_link_ok[n][k] && map_x[i] == step_x(map_x[n], k[1:0])
                      && map_y[i] == step_y(map_y[n], k[1:0])) begin
                     map_link[n][k] = i[7:0];
                     map_link_ok[n][k] = 1'b1;
                     map_link[i][k ^ 2] = n[7:0];
                     map_link_ok[i][k ^ 2] = 1'b1;
                     break;
                  end
               end
            end
            return tile_view(n);
         end
         ACT_FIND: begin
            for (int unsigned i = 0; i <= map_last; i++)
               if (map_x[i] == q.find_x && map_y[i] == q.find_y) return tile_view(i);
            return miss(STAT_NONE);
         end
         ACT_NEIGH: begin
            if (b > map_last || !map_link_ok[b][d]) return miss(STAT_NONE);
            return tile_view(map_link[b][d]);
         end
         default: return miss(STAT_NONE);
      endcase
   endfunction

   function automatic tile_req_type mk(logic [1:0] a, logic [7:0] t, logic [1:0] d,
                                       logic [15:0] p, logic [7:0] fx, logic [7:0] fy);
      tile_req_type q;
      q = '{a, t, d, p, fx, fy};
      return q;
   endfunction

   // Directed row checked against the predictor.
   function automatic row_type pred_row(tile_req_type q);
      row_type r;
      r.q = q;
      r.fixed = 1'b0;
      r.exp = miss(STAT_OK);
      return r;
   endfunction

   // Directed row with the response typed in.
   function automatic row_type fixed_row(tile_req_type q, tile_rsp_type e);
      row_type r;
      r.q = q;
      r.fixed = 1'b1;
      r.exp = e;
      return r;
   endfunction

   // Offer one request, holding it until accepted; idle beforehand at random.
   task automatic send_req(tile_req_type q, bit fixed, tile_rsp_type fixed_rsp);
      tile_rsp_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, q.find_y, q.find_x, q.tile_payload, q.direction, q.tile_index,
                    q.action};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // accepted at this edge: predict now, in request order
      pred = map_apply(q);
      if (fixed) begin
         pending_rsp.push_back(fixed_rsp);
      end else begin
         pending_rsp.push_back(pred);
      end
   endtask

   task automatic send_pred(tile_req_type q);
      send_req(q, 1'b0, miss(STAT_OK));
   endtask

   // Drain the response side: random stalls, plus the long hold-off on request.
   initial begin
      int stall;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            for (stall = 0; stall < 3000; stall++) @(posedge clock);
            hold_off = 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check each accepted response against the oldest prediction.
   always @(posedge clock) begin
      tile_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[1:0], rsp_tdata[9:2], rsp_tdata[17:10], rsp_tdata[25:18],
                 rsp_tdata[41:26]};
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response %p", $time, got);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected %p actual %p", $time, want, got);
               fail_count++;
            end
         end
      end
   end

   task automatic wait_drain();
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Random request biased toward well-formed adds and hits on stored tiles.
   function automatic tile_req_type rand_req();
      tile_req_type q;
      int unsigned sel;
      int unsigned t;
      sel = $urandom_range(99);
      t = $urandom_range(map_last);
      q = mk(ACT_FIND, 8'($urandom), 2'($urandom), 16'($urandom), 8'($urandom),
             8'($urandom));
      if (sel < 40) begin
         q.action = ACT_ADD;
         q.tile_index = t[7:0];
      end else if (sel < 65) begin
         q.action = ACT_FIND;
         q.find_x = ($urandom_range(3) != 0) ? map_x[t] : step_x(map_x[t], 2'($urandom));
         q.find_y = ($urandom_range(3) != 0) ? map_y[t] : step_y(map_y[t], 2'($urandom));
      end else if (sel < 90) begin
         q.action = ACT_NEIGH;
         q.tile_index = t[7:0];
      end else begin
         // noise: random action, raw base that may lie past the table, raw coordinates
         q.action = 2'($urandom);
      end
      return q;
   endfunction

   row_type directed [$];
   initial begin
      map_last = 0;
      map_x[0] = '0;
      map_y[0] = '0;
      map_pay[0] = '0;
      for (int k = 0; k < 4; k++) map_link_ok[0][k] = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: start tile, empty links, bad base, unused action, all directions
      directed = '{
         fixed_row(mk(ACT_FIND, 8'd0, DIR_EAST, 16'h0000, 8'h00, 8'h00),
                   rsp(STAT_OK, 8'd0, 8'h00, 8'h00, 16'h0000)),
         fixed_row(mk(ACT_NEIGH, 8'd0, DIR_NORTH, 16'h0000, 8'h00, 8'h00), miss(STAT_NONE)),
         fixed_row(mk(ACT_NEIGH, 8'd255, DIR_SOUTH, 16'hFFFF, 8'h80, 8'h7F),
                   miss(STAT_NONE)),
         fixed_row(mk(ACT_ADD, 8'd255, DIR_EAST, 16'hFFFF, 8'hFF, 8'hFF), miss(STAT_NONE)),
         fixed_row(mk(ACT_UNUSED, 8'd0, DIR_WEST, 16'h1234, 8'h00, 8'h00), miss(STAT_NONE)),
         fixed_row(mk(ACT_ADD, 8'd0, DIR_EAST, 16'hFFFF, 8'h00, 8'h00),
                   rsp(STAT_OK, 8'd1, 8'h01, 8'h00, 16'hFFFF)),
         pred_row(mk(ACT_ADD, 8'd1, DIR_NORTH, 16'h0001, 8'h00, 8'h00)),
         pred_row(mk(ACT_ADD, 8'd0, DIR_NORTH, 16'hA5A5, 8'h00, 8'h00)),
         pred_row(mk(ACT_ADD, 8'd0, DIR_WEST, 16'h5A5A, 8'h00, 8'h00)),
         pred_row(mk(ACT_ADD, 8'd0, DIR_SOUTH, 16'h0000, 8'h00, 8'h00)),
         pred_row(mk(ACT_ADD, 8'd0, DIR_EAST, 16'h7777, 8'h00, 8'h00)),
         pred_row(mk(ACT_NEIGH, 8'd3, DIR_EAST, 16'h0000, 8'h00, 8'h00)),
         pred_row(mk(ACT_NEIGH, 8'd0, DIR_EAST, 16'h0000, 8'h00, 8'h00)),
         pred_row(mk(ACT_FIND, 8'd0, DIR_EAST, 16'h0000, 8'h01, 8'h00)),
         pred_row(mk(ACT_FIND, 8'd0, DIR_EAST, 16'h0000, 8'h80, 8'h7F)),
         pred_row(mk(ACT_FIND, 8'd0, DIR_EAST, 16'h0000, 8'hFF, 8'h00))
      };
      foreach (directed[i]) send_req(directed[i].q, directed[i].fixed, directed[i].exp);

      // random phases: idling as set, then swapped, then none; a long hold-off in the first
      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin
            send_idle_pct = 79;
            recv_idle_pct = 27;
         end else if (ph == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < 505; n++) begin
            if (ph == 0 && n == 50) hold_off = 1'b1;
            send_pred(rand_req());
         end
      end

      // fill the table, then hit full and wrap past the coordinate edge
      send_idle_pct = 10;
      recv_idle_pct = 10;
      while (map_last < SLOTS - 1) begin
         send_pred(mk(ACT_ADD, map_last[7:0], DIR_EAST, 16'($urandom), 8'h00, 8'h00));
      end
      for (int n = 0; n < 20; n++) send_pred(rand_req());
      send_pred(mk(ACT_ADD, 8'd0, DIR_WEST, 16'hFFFF, 8'h00, 8'h00));
      send_pred(mk(ACT_FIND, 8'd0, DIR_EAST, 16'h0000, 8'h80, 8'h00));
      req_tvalid <= 1'b0;

      wait_drain();
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #4000000;
      $display("simulation failed");
      $finish;
   end

endmodule
